[hw/rtl/ifrx_pkg.sv]
package ifrx_pkg;

	localparam int RING_BYTES_DEF  = 256;
	localparam int QUEUE_SLOTS_DEF = 8;
	localparam int SLOT_MAX_DEF    = 64;

	// Widest ring position the parameter range allows.
	localparam int POS_W_MAX = 12;

	typedef enum logic [2:0] {
		ACT_RX      = 3'd0,
		ACT_IDLE    = 3'd1,
		ACT_POP     = 3'd2,
		ACT_OVERRUN = 3'd3,
		ACT_CLEAR   = 3'd4
	} action_t;

	typedef enum logic [2:0] {
		KIND_BYTE        = 3'd0,
		KIND_QUEUED      = 3'd1,
		KIND_DROPPED     = 3'd2,
		KIND_IDLE_EMPTY  = 3'd3,
		KIND_QUEUE_EMPTY = 3'd4,
		KIND_ZERO_POP    = 3'd5,
		KIND_OVERRUN     = 3'd6
	} kind_t;

	typedef enum logic [2:0] {
		OP_WRITE,
		OP_FRAME,
		OP_POP,
		OP_OVERRUN,
		OP_CLEAR
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [7:0]           data;
		logic [POS_W_MAX-1:0] pos;
		logic [POS_W_MAX-1:0] len;
	} cmd_t;

	typedef enum logic [2:0] {
		BS_READY,
		BS_RESULT,
		BS_COPY_RD,
		BS_COPY_WR,
		BS_POP_RD,
		BS_POP_EMIT
	} bstate_t;

	localparam int CFG_SLOT_BYTES_MAX   = 0;
	localparam int CFG_QUEUE_DEPTH_USED = 1;

endpackage

[hw/rtl/ifrx_front.sv]
module ifrx_front #(
	parameter int RING_BYTES = 256
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [2:0]           action,
	input  logic [7:0]           rx_byte,
	input  logic                 overrun_seen,
	input  logic [7:0]           buf_size,
	input  logic                 q_full,
	output logic                 q_push,
	output ifrx_pkg::cmd_t       q_cmd
);
	import ifrx_pkg::*;

	localparam int AW = $clog2(RING_BYTES);

	logic [AW-1:0] write_pos_q, frame_start_q, wp_next;
	logic [AW:0]   span;
	logic          accept;
	action_t       act;

	assign act      = action_t'(action);
	assign in_stall = q_full;
	assign accept   = in_valid && !q_full;
	assign wp_next  = (write_pos_q == AW'(RING_BYTES - 1)) ? '0 : write_pos_q + 1'b1;
	// Wrapped distance from the frame start to the write position.
	assign span = (write_pos_q >= frame_start_q) ?
		({1'b0, write_pos_q} - {1'b0, frame_start_q}) :
		((AW+1)'(RING_BYTES) - {1'b0, frame_start_q} + {1'b0, write_pos_q});

	always_comb begin
		q_push = 1'b0;
		q_cmd.op   = OP_WRITE;
		q_cmd.data = rx_byte;
		q_cmd.pos  = POS_W_MAX'(write_pos_q);
		q_cmd.len  = POS_W_MAX'(buf_size);
		if (accept) begin
			unique case (act)
				ACT_RX: begin
					q_push = 1'b1;
				end
				ACT_IDLE: begin
					q_push    = 1'b1;
					q_cmd.op  = overrun_seen ? OP_OVERRUN : OP_FRAME;
					q_cmd.pos = POS_W_MAX'(frame_start_q);
					q_cmd.len = POS_W_MAX'(span[AW-1:0]);
				end
				ACT_POP: begin
					q_push   = 1'b1;
					q_cmd.op = OP_POP;
				end
				ACT_OVERRUN: begin
					q_push   = 1'b1;
					q_cmd.op = OP_OVERRUN;
				end
				ACT_CLEAR: begin
					q_push   = 1'b1;
					q_cmd.op = OP_CLEAR;
				end
				default: q_push = 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			write_pos_q   <= '0;
			frame_start_q <= '0;
		end else if (accept) begin
			unique case (act)
				ACT_RX: write_pos_q <= wp_next;
				ACT_IDLE: begin
					if (overrun_seen) begin
						write_pos_q   <= '0;
						frame_start_q <= '0;
					end else begin
						frame_start_q <= write_pos_q;
					end
				end
				ACT_OVERRUN, ACT_CLEAR: begin
					write_pos_q   <= '0;
					frame_start_q <= '0;
				end
				default: ;
			endcase
		end
	end

endmodule

[hw/rtl/ifrx_cmd_queue.sv]
module ifrx_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ifrx_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           pop_valid,
	output ifrx_pkg::cmd_t pop_cmd
);
	import ifrx_pkg::*;

	cmd_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_pop;

	assign full      = count_q == 2'd2;
	assign pop_valid = count_q != 2'd0;
	assign pop_cmd   = entry_q[rd_ptr_q];
	assign do_pop    = pop && pop_valid;

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (do_pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, do_pop};
		end
	end

endmodule

[hw/rtl/ifrx_back.sv]
module ifrx_back #(
	parameter int RING_BYTES  = 256,
	parameter int QUEUE_SLOTS = 8,
	parameter int SLOT_MAX    = 64
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	input  ifrx_pkg::cmd_t cmd,
	output logic           cmd_ready,
	input  logic [6:0]     slot_bytes_max,
	input  logic [3:0]     queue_depth_used,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [2:0]     kind,
	output logic [7:0]     data_byte,
	output logic [6:0]     frame_length,
	output logic           last_of_run,
	output logic [3:0]     frames_waiting,
	output logic [6:0]     oldest_length
);
	import ifrx_pkg::*;

	localparam int AW  = $clog2(RING_BYTES);
	localparam int QW  = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;
	localparam int CW  = $clog2(QUEUE_SLOTS + 1);
	localparam int SW  = (SLOT_MAX > 1) ? $clog2(SLOT_MAX) : 1;
	localparam int SLOT_WORDS = QUEUE_SLOTS * (2 ** SW);

	bstate_t state_q, state_d;

	logic [7:0]    ring_mem [RING_BYTES];
	logic [7:0]    slot_mem [SLOT_WORDS];
	logic [7:0]    ring_rd_q, slot_rd_q;
	logic [6:0]    stored_len_q [QUEUE_SLOTS];

	logic [QW-1:0] head_q, tail_q, pslot_q;
	logic [CW-1:0] count_q, eff_depth;
	logic [AW-1:0] pos_q;
	logic [6:0]    idx_q, run_len_q, eff_max, pop_len;
	kind_t         res_kind_q;
	logic [6:0]    res_len_q;
	logic [POS_W_MAX-1:0] take_len;

	logic out_free, ring_we, slot_we, out_load, last_idx;

	function automatic logic [QW-1:0] next_slot(input logic [QW-1:0] idx,
		input logic [CW-1:0] depth);
		logic [CW:0] nx;
		nx = (CW+1)'(idx) + 1'b1;
		return (nx >= {1'b0, depth}) ? '0 : QW'(nx);
	endfunction

	always_comb begin
		eff_depth = CW'(queue_depth_used);
		if (queue_depth_used == 4'd0) eff_depth = CW'(1);
		if ({1'b0, queue_depth_used} > 5'(QUEUE_SLOTS)) eff_depth = CW'(QUEUE_SLOTS);
		eff_max = slot_bytes_max;
		if (slot_bytes_max == 7'd0) eff_max = 7'd1;
		if (slot_bytes_max > 7'(SLOT_MAX)) eff_max = 7'(SLOT_MAX);
	end

	assign take_len = (cmd.len > POS_W_MAX'(eff_max)) ? POS_W_MAX'(eff_max) : cmd.len;
	assign pop_len  = ({1'b0, stored_len_q[tail_q]} > {1'b0, cmd.len[6:0]} || cmd.len[7]) ?
		((cmd.len[7:0] > {1'b0, stored_len_q[tail_q]}) ? stored_len_q[tail_q] :
			cmd.len[6:0]) :
		stored_len_q[tail_q];
	assign out_free = !out_valid || !out_stall;
	assign last_idx = (idx_q + 1'b1) == run_len_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			BS_READY: begin
				if (cmd_valid) begin
					unique case (cmd.op)
						OP_OVERRUN: state_d = BS_RESULT;
						OP_FRAME: begin
							if (cmd.len == '0 || count_q >= eff_depth) state_d = BS_RESULT;
							else state_d = BS_COPY_RD;
						end
						OP_POP: begin
							if (count_q == '0 || pop_len == 7'd0) state_d = BS_RESULT;
							else state_d = BS_POP_RD;
						end
						default: state_d = BS_READY;
					endcase
				end
			end
			BS_RESULT:   if (out_free) state_d = BS_READY;
			BS_COPY_RD:  state_d = BS_COPY_WR;
			BS_COPY_WR:  state_d = last_idx ? BS_RESULT : BS_COPY_RD;
			BS_POP_RD:   state_d = BS_POP_EMIT;
			BS_POP_EMIT: if (out_free) state_d = last_idx ? BS_READY : BS_POP_RD;
			default:     state_d = BS_READY;
		endcase
	end

	always_comb begin
		cmd_ready = state_q == BS_READY;
		ring_we   = cmd_ready && cmd_valid && cmd.op == OP_WRITE;
		slot_we   = state_q == BS_COPY_WR;
		out_load  = out_free && (state_q == BS_RESULT || state_q == BS_POP_EMIT);
	end

	always_ff @(posedge clk) begin
		if (ring_we) ring_mem[cmd.pos[AW-1:0]] <= cmd.data;
		ring_rd_q <= ring_mem[pos_q];
	end

	always_ff @(posedge clk) begin
		if (slot_we) slot_mem[{head_q, idx_q[SW-1:0]}] <= ring_rd_q;
		slot_rd_q <= slot_mem[{pslot_q, idx_q[SW-1:0]}];
	end

	always_ff @(posedge clk) begin
		if (state_q == BS_COPY_WR && last_idx) stored_len_q[head_q] <= run_len_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= BS_READY;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			out_valid  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) out_valid <= 1'b1;
			else if (!out_stall) out_valid <= 1'b0;
			if (state_q == BS_READY && cmd_valid) begin
				unique case (cmd.op)
					OP_CLEAR: begin
						head_q  <= '0;
						tail_q  <= '0;
						count_q <= '0;
					end
					OP_POP: begin
						if (count_q != '0) begin
							tail_q  <= next_slot(tail_q, eff_depth);
							count_q <= count_q - 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == BS_COPY_WR && last_idx) begin
				head_q  <= next_slot(head_q, eff_depth);
				count_q <= count_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			BS_READY: begin
				idx_q     <= '0;
				pos_q     <= cmd.pos[AW-1:0];
				pslot_q   <= tail_q;
				res_len_q <= '0;
				run_len_q <= take_len[6:0];
				unique case (cmd.op)
					OP_FRAME: begin
						if (cmd.len == '0) res_kind_q <= KIND_IDLE_EMPTY;
						else res_kind_q <= KIND_DROPPED;
					end
					OP_POP: begin
						run_len_q <= pop_len;
						if (count_q == '0) res_kind_q <= KIND_QUEUE_EMPTY;
						else res_kind_q <= KIND_ZERO_POP;
					end
					default: res_kind_q <= KIND_OVERRUN;
				endcase
			end
			BS_COPY_WR: begin
				idx_q <= idx_q + 1'b1;
				pos_q <= (pos_q == AW'(RING_BYTES - 1)) ? '0 : pos_q + 1'b1;
				if (last_idx) begin
					res_kind_q <= KIND_QUEUED;
					res_len_q  <= run_len_q;
				end
			end
			BS_POP_EMIT: if (out_free) idx_q <= idx_q + 1'b1;
			default: ;
		endcase
	end

	// Status fields are sampled after the queue pointers for this word settle.
	always_ff @(posedge clk) begin
		if (out_load) begin
			frames_waiting <= 4'(count_q);
			oldest_length  <= (count_q != '0) ? stored_len_q[tail_q] : 7'd0;
			if (state_q == BS_POP_EMIT) begin
				kind         <= KIND_BYTE;
				data_byte    <= slot_rd_q;
				frame_length <= run_len_q;
				last_of_run  <= last_idx;
			end else begin
				kind         <= res_kind_q;
				data_byte    <= 8'd0;
				frame_length <= res_len_q;
				last_of_run  <= 1'b1;
			end
		end
	end

endmodule

[hw/rtl/idle_framed_rx_frame_fifo.sv]
// Idle-framed receive frame queue.
// Input channel (in_valid/in_stall) takes one word per item: a received byte,
// a line-idle event, a frame pop, an overrun recovery or a clear. Result words
// leave on out_valid/out_stall; last_of_run marks the final word of an item.
// Registers are written on cfg_valid/cfg_ready (index 0 slot byte limit,
// index 1 queue depth); the user writes them only while the block is idle,
// which the block itself does not enforce.
// A front stage tracks ring positions and classifies each item into a
// two-entry command queue; a back stage owns the ring and slot memories.
// The back stage writes a received byte to the ring or applies a clear and
// stays ready for the next command. An idle event that queues a frame reads
// each copied byte from the ring and then writes it to its slot; a pop reads
// each delivered byte from its slot and then emits it; other events give a
// single result word. The ring and slot memories have registered reads, and
// the back stage takes no new command until it is done with the current one.
// When the receiver stalls, the output register holds its word and the back
// stage waits; the front keeps accepting until the command queue is full.
// Reset empties the frame queue and returns both ring positions to zero; the
// memories are not cleared and need no clearing pass.
module idle_framed_rx_frame_fifo #(
	parameter int RING_BYTES  = ifrx_pkg::RING_BYTES_DEF,
	parameter int QUEUE_SLOTS = ifrx_pkg::QUEUE_SLOTS_DEF,
	parameter int SLOT_MAX    = ifrx_pkg::SLOT_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [2:0] action,
	input  logic [7:0] rx_byte,
	input  logic       overrun_seen,
	input  logic [7:0] buf_size,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [2:0] kind,
	output logic [7:0] data_byte,
	output logic [6:0] frame_length,
	output logic       last_of_run,
	output logic [3:0] frames_waiting,
	output logic [6:0] oldest_length,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [6:0] cfg_data
);
	import ifrx_pkg::*;

	logic [6:0] slot_bytes_max_q;
	logic [3:0] queue_depth_used_q;
	logic       q_full, q_push, c_valid, c_ready;
	cmd_t       q_cmd, c_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_bytes_max_q   <= 7'd64;
			queue_depth_used_q <= 4'd8;
		end else if (cfg_valid) begin
			if (cfg_index == 2'(CFG_SLOT_BYTES_MAX)) slot_bytes_max_q <= cfg_data;
			if (cfg_index == 2'(CFG_QUEUE_DEPTH_USED)) queue_depth_used_q <= cfg_data[3:0];
		end
	end

	ifrx_front #(.RING_BYTES(RING_BYTES)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .action, .rx_byte, .overrun_seen,
		.buf_size, .q_full, .q_push, .q_cmd
	);

	ifrx_cmd_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_cmd(q_cmd), .full(q_full),
		.pop(c_ready), .pop_valid(c_valid), .pop_cmd(c_cmd)
	);

	ifrx_back #(
		.RING_BYTES(RING_BYTES), .QUEUE_SLOTS(QUEUE_SLOTS), .SLOT_MAX(SLOT_MAX)
	) u_back (
		.clk, .arst_n, .cmd_valid(c_valid), .cmd(c_cmd), .cmd_ready(c_ready),
		.slot_bytes_max(slot_bytes_max_q), .queue_depth_used(queue_depth_used_q),
		.out_valid, .out_stall, .kind, .data_byte, .frame_length, .last_of_run,
		.frames_waiting, .oldest_length
	);

	a_byte_len: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && kind == KIND_BYTE |-> frame_length != 7'd0)
		else $error("frame byte word with zero length");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 5'(frames_waiting) <= 5'(QUEUE_SLOTS) || QUEUE_SLOTS == 16)
		else $error("frame count beyond queue size");

	a_empty_oldest: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && frames_waiting == 4'd0 && QUEUE_SLOTS < 16 |-> oldest_length == 7'd0)
		else $error("oldest length reported with empty queue");

endmodule

[test/tb.sv]
`timescale 1ns / 100ps

module tb;
	import ifrx_pkg::*;

	typedef struct {
		logic [2:0] kind;
		logic [7:0] data;
		logic [6:0] len;
		logic       last;
		logic [3:0] waiting;
		logic [6:0] oldest;
	} word_t;

	typedef struct {
		logic [2:0] act;
		logic [7:0] byte_in;
		logic       ovr;
		logic [7:0] bsize;
		bit         typed;
		word_t      word;
	} row_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_stall;
	logic [2:0] action = '0;
	logic [7:0] rx_byte = '0;
	logic       overrun_seen = 1'b0;
	logic [7:0] buf_size = '0;
	logic       out_valid;
	logic       out_stall = 1'b0;
	logic [2:0] kind;
	logic [7:0] data_byte;
	logic [6:0] frame_length;
	logic       last_of_run;
	logic [3:0] frames_waiting;
	logic [6:0] oldest_length;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [6:0] cfg_data = '0;

	idle_framed_rx_frame_fifo uut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow of the block.
	logic [7:0] ring [256];
	logic [7:0] slot_data [8][64];
	logic [6:0] shadow_len [8];
	logic [7:0] wr_pos, start_pos;
	int unsigned head, tail, count;
	logic [6:0] limit_reg;
	logic [3:0] depth_reg;

	word_t expected_words[$];
	word_t pending[$];
	int fails = 0;
	int items_sent = 0;
	int words_seen = 0;
	int frames_queued = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;

	function automatic int unsigned slot_limit();
		if (limit_reg == 0) return 1;
		if (limit_reg > 64) return 64;
		return limit_reg;
	endfunction

	function automatic int unsigned used_depth();
		if (depth_reg == 0) return 1;
		if (depth_reg > 8) return 8;
		return depth_reg;
	endfunction

	function automatic int unsigned advance(int unsigned idx);
		return (idx + 1 >= used_depth()) ? 0 : idx + 1;
	endfunction

	function automatic void add_word(kind_t k, logic [7:0] d, logic [6:0] l);
		word_t w;
		w.kind = k; w.data = d; w.len = l; w.last = 0; w.waiting = 0; w.oldest = 0;
		pending.push_back(w);
	endfunction

	// Works out the words one item causes into pending, updating the shadow.
	function automatic void predict_item(logic [2:0] act, logic [7:0] b, logic ovr,
			logic [7:0] bsize);
		logic [7:0] span, pos;
		int unsigned n;
		pending.delete();
		case (act)
			ACT_RX: begin
				ring[wr_pos] = b;
				wr_pos = wr_pos + 8'd1;
			end
			ACT_IDLE: begin
				if (ovr) begin
					wr_pos = 0;
					start_pos = 0;
					add_word(KIND_OVERRUN, 0, 0);
				end else begin
					span = wr_pos - start_pos;
					if (span == 0) begin
						add_word(KIND_IDLE_EMPTY, 0, 0);
					end else if (count >= used_depth()) begin
						add_word(KIND_DROPPED, 0, 0);
					end else begin
						n = (span > slot_limit()) ? slot_limit() : span;
						pos = start_pos;
						for (int i = 0; i < n; i++) begin
							slot_data[head][i] = ring[pos];
							pos = pos + 8'd1;
						end
						shadow_len[head] = 7'(n);
						head = advance(head);
						count++;
						frames_queued++;
						add_word(KIND_QUEUED, 0, 7'(n));
					end
					start_pos = wr_pos;
				end
			end
			ACT_POP: begin
				if (count == 0) begin
					add_word(KIND_QUEUE_EMPTY, 0, 0);
				end else begin
					n = shadow_len[tail];
					if (n > bsize) n = bsize;
					if (n == 0) add_word(KIND_ZERO_POP, 0, 0);
					for (int i = 0; i < n; i++) add_word(KIND_BYTE, slot_data[tail][i], 7'(n));
					tail = advance(tail);
					count--;
				end
			end
			ACT_OVERRUN: begin
				wr_pos = 0;
				start_pos = 0;
				add_word(KIND_OVERRUN, 0, 0);
			end
			ACT_CLEAR: begin
				foreach (ring[i]) ring[i] = 0;
				wr_pos = 0;
				start_pos = 0;
				head = 0;
				tail = 0;
				count = 0;
			end
			default: ;
		endcase
		foreach (pending[i]) begin
			pending[i].last = (i == pending.size() - 1);
			pending[i].waiting = 4'(count);
			pending[i].oldest = (count > 0) ? shadow_len[tail] : 7'd0;
		end
	endfunction

	task automatic send_item(logic [2:0] act, logic [7:0] b, logic ovr, logic [7:0] bsize,
			bit typed = 0, word_t typed_word = '{default: 0});
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		rx_byte <= b;
		overrun_seen <= ovr;
		buf_size <= bsize;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_item(act, b, ovr, bsize);
		if (typed) expected_words.push_back(typed_word);
		else foreach (pending[i]) expected_words.push_back(pending[i]);
		if (act <= ACT_CLEAR) items_sent++;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [6:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == 2'(CFG_SLOT_BYTES_MAX)) limit_reg = val;
		else depth_reg = val[3:0];
	endtask

	task automatic reconfigure(logic [6:0] limit_val, logic [3:0] depth_val);
		// Empty the frame queue first so no slot is left waiting across a depth change.
		while (count != 0) send_item(ACT_POP, 8'($urandom), 1'($urandom), 8'hFF);
		settle();
		cfg_write(2'(CFG_SLOT_BYTES_MAX), limit_val);
		cfg_write(2'(CFG_QUEUE_DEPTH_USED), {3'b000, depth_val});
		cfg_valid <= 1'b0;
	endtask

	task automatic random_phase(int n_items);
		int stop_at;
		int nb;
		int pick;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			pick = $urandom_range(9);
			if (pick <= 6) begin
				nb = $urandom_range(19);
				if (nb == 0) nb = $urandom_range(40, 70);
				else nb = $urandom_range(1, 8);
				repeat (nb) send_item(ACT_RX, 8'($urandom), 1'($urandom), 8'($urandom));
				send_item(ACT_IDLE, 8'($urandom), $urandom_range(9) == 0, 8'($urandom));
				if ($urandom_range(1))
					send_item(ACT_POP, 8'($urandom), 1'($urandom),
						8'($urandom_range(3) == 0 ? $urandom_range(255) : 255));
			end else if (pick == 7) begin
				send_item(ACT_POP, 8'($urandom), 1'($urandom), 8'($urandom));
			end else if (pick == 8) begin
				send_item($urandom_range(1) ? ACT_OVERRUN : ACT_CLEAR, 8'($urandom),
					1'($urandom), 8'($urandom));
			end else begin
				send_item(3'($urandom_range(7)), 8'($urandom), 1'($urandom), 8'($urandom));
			end
		end
	endtask

	always @(posedge clk) begin
		if (recv_idle_pct == 0) out_stall <= 1'b0;
		else out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	always @(posedge clk) begin
		word_t w;
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				$error("Unexpected word: kind %0d data %0h", kind, data_byte);
				fails++;
			end else begin
				w = expected_words.pop_front();
				if (kind !== w.kind) begin
					$error("kind: expected %0d, got %0d", w.kind, kind);
					fails++;
				end
				if (data_byte !== w.data) begin
					$error("data_byte: expected %0h, got %0h", w.data, data_byte);
					fails++;
				end
				if (frame_length !== w.len) begin
					$error("frame_length: expected %0d, got %0d", w.len, frame_length);
					fails++;
				end
				if (last_of_run !== w.last) begin
					$error("last_of_run: expected %0d, got %0d", w.last, last_of_run);
					fails++;
				end
				if (frames_waiting !== w.waiting) begin
					$error("frames_waiting: expected %0d, got %0d", w.waiting, frames_waiting);
					fails++;
				end
				if (oldest_length !== w.oldest) begin
					$error("oldest_length: expected %0d, got %0d", w.oldest, oldest_length);
					fails++;
				end
			end
		end
	end

	initial begin
		#20_000_000;
		$display("Regression FAIL");
		$finish;
	end

	initial begin
		row_t rows[$];
		logic [6:0] limits [6] = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd20, 7'd64};
		logic [3:0] depths [6] = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd3, 4'd8};
		int unsigned pct_send [6] = '{37, 37, 75, 75, 0, 0};
		int unsigned pct_recv [6] = '{75, 75, 37, 37, 0, 0};

		foreach (ring[i]) ring[i] = 0;
		wr_pos = 0; start_pos = 0; head = 0; tail = 0; count = 0;
		limit_reg = 64; depth_reg = 8;

		// Directed rows; typed expectations where the answer is plain.
		rows = '{
			'{ACT_POP,     8'h00, 0, 8'h00, 1, '{KIND_QUEUE_EMPTY, 0, 0, 1, 0, 0}},
			'{ACT_IDLE,    8'hFF, 0, 8'hFF, 1, '{KIND_IDLE_EMPTY, 0, 0, 1, 0, 0}},
			'{ACT_RX,      8'h00, 0, 8'h00, 0, '{default: 0}},
			'{ACT_RX,      8'hFF, 1, 8'hFF, 0, '{default: 0}},
			'{ACT_RX,      8'hA5, 0, 8'h00, 0, '{default: 0}},
			'{ACT_IDLE,    8'h00, 0, 8'h00, 1, '{KIND_QUEUED, 0, 3, 1, 1, 3}},
			'{ACT_POP,     8'h00, 0, 8'hFF, 0, '{default: 0}},
			'{ACT_RX,      8'h5A, 0, 8'h00, 0, '{default: 0}},
			'{ACT_IDLE,    8'h00, 1, 8'h00, 1, '{KIND_OVERRUN, 0, 0, 1, 0, 0}},
			'{ACT_OVERRUN, 8'hFF, 1, 8'hFF, 1, '{KIND_OVERRUN, 0, 0, 1, 0, 0}},
			'{ACT_RX,      8'h3C, 0, 8'h00, 0, '{default: 0}},
			'{ACT_IDLE,    8'h00, 0, 8'h00, 1, '{KIND_QUEUED, 0, 1, 1, 1, 1}},
			'{ACT_POP,     8'h00, 0, 8'h00, 1, '{KIND_ZERO_POP, 0, 0, 1, 0, 0}},
			'{3'd5,        8'hFF, 1, 8'hFF, 0, '{default: 0}},
			'{3'd6,        8'h00, 0, 8'h00, 0, '{default: 0}},
			'{3'd7,        8'h55, 1, 8'hAA, 0, '{default: 0}},
			'{ACT_RX,      8'h81, 0, 8'h00, 0, '{default: 0}},
			'{ACT_CLEAR,   8'h00, 0, 8'h00, 0, '{default: 0}},
			'{ACT_IDLE,    8'h00, 0, 8'h00, 1, '{KIND_IDLE_EMPTY, 0, 0, 1, 0, 0}},
			'{ACT_RX,      8'h7E, 0, 8'h00, 0, '{default: 0}},
			'{ACT_RX,      8'h01, 0, 8'h00, 0, '{default: 0}},
			'{ACT_IDLE,    8'h00, 0, 8'h00, 0, '{default: 0}},
			'{ACT_IDLE,    8'h00, 0, 8'h00, 1, '{KIND_IDLE_EMPTY, 0, 0, 1, 1, 2}},
			'{ACT_POP,     8'h00, 0, 8'h01, 0, '{default: 0}}
		};

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 6; p++) begin
			reconfigure(limits[p], depths[p]);
			send_idle_pct = pct_send[p];
			recv_idle_pct = pct_recv[p];
			if (p == 0)
				foreach (rows[i])
					send_item(rows[i].act, rows[i].byte_in, rows[i].ovr, rows[i].bsize,
						rows[i].typed, rows[i].word);
			random_phase(48);
		end

		in_valid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);

		$display("Sent %0d items over six register settings; %0d frames queued.",
			items_sent, frames_queued);
		$display("Checked %0d result words with a shadow model of the queue.", words_seen);
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/ifrx_pkg.sv
hw/rtl/ifrx_front.sv
hw/rtl/ifrx_cmd_queue.sv
hw/rtl/ifrx_back.sv
hw/rtl/idle_framed_rx_frame_fifo.sv
test/tb.sv
